// ===== sv/dtc_pkg.sv =====
// dtc_pkg: types, constants and helpers shared by the dispense timer blocks.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package dtc_pkg;

  localparam int TICK_W = 16;
  localparam int VOL_W  = 13;
  localparam int EXTRA_W = 8;
  localparam int CUP_W  = 2;
  localparam int PROD_W = TICK_W + VOL_W;
  localparam int DIV_CNT_W = $clog2(PROD_W);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MODEL       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_WIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_HALF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_ONE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_TWO   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_LITER = 3'd6;

  localparam logic [TICK_W-1:0]  RST_CHECK_WIN   = 16'd6000;
  localparam logic [TICK_W-1:0]  RST_MAX_WIN     = 16'd15000;
  localparam logic [EXTRA_W-1:0] RST_EXTRA_HALF  = 8'd10;
  localparam logic [EXTRA_W-1:0] RST_EXTRA_ONE   = 8'd10;
  localparam logic [EXTRA_W-1:0] RST_EXTRA_TWO   = 8'd23;
  localparam logic [EXTRA_W-1:0] RST_EXTRA_LITER = 8'd33;

  localparam logic [VOL_W-1:0] VOL_TRIGGER = 13'd2000;
  localparam logic [VOL_W-1:0] VOL_CAP     = 13'd5000;

  localparam logic [VOL_W-1:0] CUP_SMALL_HALF  = 13'd120;
  localparam logic [VOL_W-1:0] CUP_SMALL_ONE   = 13'd250;
  localparam logic [VOL_W-1:0] CUP_SMALL_LARGE = 13'd500;
  localparam logic [VOL_W-1:0] CUP_BIG_HALF    = 13'd250;
  localparam logic [VOL_W-1:0] CUP_BIG_ONE     = 13'd500;
  localparam logic [VOL_W-1:0] CUP_BIG_LARGE   = 13'd1000;

  localparam logic [CUP_W-1:0] CUP_HALF = 2'd0;
  localparam logic [CUP_W-1:0] CUP_ONE  = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_ACC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic div_step;
    logic acc;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
  } sts_t;

  // nominal volume of the running dispense
  function automatic logic [VOL_W-1:0] pick_size(input logic cont,
                                                 input logic [CUP_W-1:0] cup,
                                                 input logic big);
    logic [VOL_W-1:0] r;
    if (cont) begin
      r = VOL_CAP;
    end else if (cup == CUP_HALF) begin
      r = big ? CUP_BIG_HALF : CUP_SMALL_HALF;
    end else if (cup == CUP_ONE) begin
      r = big ? CUP_BIG_ONE : CUP_SMALL_ONE;
    end else begin
      r = big ? CUP_BIG_LARGE : CUP_SMALL_LARGE;
    end
    return r;
  endfunction

endpackage

// ===== sv/dispense_timer_with_compensation.sv =====
// dispense_timer_with_compensation: top level, controller plus datapath.
// Depends on dtc_pkg, dtc_ctrl and dtc_datapath.
//
// Each input beat is one tick of the dispense timer; each tick yields exactly
// one result beat (outlet state, end pulse, volume estimate, compensation flag).
// Channels: in_valid/in_ready for ticks, out_valid/out_ready for results, and
// cfg_valid/cfg_ready with cfg_index/cfg_data for register writes (cfg_ready
// is always high; unknown indexes are dropped).
// An ordinary tick goes through capture, update and emit into the output register. The tick
// on which a dispense has closed and the volume estimate is folded in also runs a
// 29-step restoring divider, one quotient bit a cycle, before the sum is taken.
// One tick is in flight at a time; in_ready is high again once the result is
// in the output register, so the next tick is taken while it waits.
// If the receiver stalls, the finished tick holds in the controller until the
// output register frees up, and no further tick is accepted meanwhile.
// Reset (rst, synchronous) clears all tick state and loads the register
// defaults; it takes effect on the next clock edge.
`timescale 1ns / 1ps

module dispense_timer_with_compensation (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                start_req,
  input  logic                                stop,
  input  logic                                continuous,
  input  logic [dtc_pkg::CUP_W-1:0]           cup_level,
  input  logic [dtc_pkg::TICK_W-1:0]          base_time,
  input  logic                                tank_full,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                dispensing,
  output logic                                dispense_end,
  output logic [dtc_pkg::VOL_W-1:0]           volume_sum,
  output logic                                compensating,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dtc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dtc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  dtc_pkg::cmd_t cmd;
  dtc_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  dtc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dtc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .start_req    (start_req),
    .stop         (stop),
    .continuous   (continuous),
    .cup_level    (cup_level),
    .base_time    (base_time),
    .tank_full    (tank_full),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .dispensing   (dispensing),
    .dispense_end (dispense_end),
    .volume_sum   (volume_sum),
    .compensating (compensating)
  );

  // one tick at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("tick accepted while another is in flight");

  // an end pulse always comes with the outlet closed
  a_end_closes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && dispense_end) |-> !dispensing)
    else $error("end pulse with outlet still open");

  // volume estimate is capped
  a_vol_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (volume_sum <= dtc_pkg::VOL_CAP))
    else $error("volume estimate above cap");

  // a result only appears after a tick has been taken
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a tick");

endmodule

// ===== sv/dtc_ctrl.sv =====
// dtc_ctrl: sequencer for one tick: capture, update, optional divide, emit.
// Depends on dtc_pkg.
`timescale 1ns / 1ps

module dtc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  dtc_pkg::sts_t sts,
  output dtc_pkg::cmd_t cmd
);

  dtc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dtc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      dtc_pkg::ST_IDLE: begin
        if (in_valid) state_next = dtc_pkg::ST_EXEC;
      end
      dtc_pkg::ST_EXEC: begin
        state_next = sts.need_div ? dtc_pkg::ST_DIV : dtc_pkg::ST_EMIT;
      end
      dtc_pkg::ST_DIV: begin
        if (sts.div_last) state_next = dtc_pkg::ST_ACC;
      end
      dtc_pkg::ST_ACC: begin
        state_next = dtc_pkg::ST_EMIT;
      end
      dtc_pkg::ST_EMIT: begin
        if (sts.out_free) state_next = dtc_pkg::ST_IDLE;
      end
      default: state_next = dtc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      dtc_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      dtc_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      dtc_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      dtc_pkg::ST_ACC: begin
        cmd.acc = 1'b1;
      end
      dtc_pkg::ST_EMIT: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== sv/dtc_datapath.sv =====
// dtc_datapath: config registers, tick state, volume divider and result register.
// Depends on dtc_pkg; driven by dtc_ctrl.
`timescale 1ns / 1ps

module dtc_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  dtc_pkg::cmd_t                       cmd,
  output dtc_pkg::sts_t                       sts,
  input  logic                                cfg_we,
  input  logic [dtc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dtc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                start_req,
  input  logic                                stop,
  input  logic                                continuous,
  input  logic [dtc_pkg::CUP_W-1:0]           cup_level,
  input  logic [dtc_pkg::TICK_W-1:0]          base_time,
  input  logic                                tank_full,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                dispensing,
  output logic                                dispense_end,
  output logic [dtc_pkg::VOL_W-1:0]           volume_sum,
  output logic                                compensating
);

  localparam int TW = dtc_pkg::TICK_W;
  localparam int VW = dtc_pkg::VOL_W;
  localparam int PW = dtc_pkg::PROD_W;
  localparam int CW = dtc_pkg::DIV_CNT_W;

  // configuration
  logic                      model_is_r_type;
  logic [TW-1:0]             check_window_ticks, max_window_ticks;
  logic [dtc_pkg::EXTRA_W-1:0] extra_half, extra_one, extra_two, extra_liter;

  // captured tick
  logic                      t_start, t_stop, t_cont, t_full;
  logic [dtc_pkg::CUP_W-1:0] t_cup;
  logic [TW-1:0]             t_base;

  // tick state
  logic                      outlet_open, continuous_latched, window_armed, extra_active;
  logic [dtc_pkg::CUP_W-1:0] cup_latched;
  logic [TW-1:0]             base_latched, run_ticks, open_ticks, nominal_total, window_ticks;
  logic [VW-1:0]             nominal_size, volume_acc;
  logic                      end_flag;

  // divider
  logic [TW-1:0]             div_rem, divisor;
  logic [PW-1:0]             div_quo;
  logic [CW-1:0]             div_cnt;

  // next values for the update cycle
  logic                      outlet_open_next, continuous_latched_next, window_armed_next;
  logic                      extra_active_next, end_flag_next, need_div;
  logic [dtc_pkg::CUP_W-1:0] cup_latched_next;
  logic [TW-1:0]             base_latched_next, run_ticks_next, open_ticks_next;
  logic [TW-1:0]             nominal_total_next, window_ticks_next;
  logic [VW-1:0]             nominal_size_next, volume_acc_next;

  logic [TW-1:0]             win_inc, ot_mid, target;
  logic [dtc_pkg::EXTRA_W-1:0] extra_pick;
  logic [TW:0]               target_sum, run_inc;
  logic [PW-1:0]             product;

  logic [TW:0]               trial;
  logic                      trial_ge;
  logic [VW-1:0]             add_clip;
  logic [VW:0]               acc_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      model_is_r_type    <= 1'b0;
      check_window_ticks <= dtc_pkg::RST_CHECK_WIN;
      max_window_ticks   <= dtc_pkg::RST_MAX_WIN;
      extra_half         <= dtc_pkg::RST_EXTRA_HALF;
      extra_one          <= dtc_pkg::RST_EXTRA_ONE;
      extra_two          <= dtc_pkg::RST_EXTRA_TWO;
      extra_liter        <= dtc_pkg::RST_EXTRA_LITER;
    end else if (cfg_we) begin
      case (cfg_index)
        dtc_pkg::CFG_MODEL:       model_is_r_type    <= cfg_data[0];
        dtc_pkg::CFG_CHECK_WIN:   check_window_ticks <= cfg_data[TW-1:0];
        dtc_pkg::CFG_MAX_WIN:     max_window_ticks   <= cfg_data[TW-1:0];
        dtc_pkg::CFG_EXTRA_HALF:  extra_half         <= cfg_data[dtc_pkg::EXTRA_W-1:0];
        dtc_pkg::CFG_EXTRA_ONE:   extra_one          <= cfg_data[dtc_pkg::EXTRA_W-1:0];
        dtc_pkg::CFG_EXTRA_TWO:   extra_two          <= cfg_data[dtc_pkg::EXTRA_W-1:0];
        dtc_pkg::CFG_EXTRA_LITER: extra_liter        <= cfg_data[dtc_pkg::EXTRA_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      t_start <= start_req;
      t_stop  <= stop;
      t_cont  <= continuous;
      t_cup   <= cup_level;
      t_base  <= base_time;
      t_full  <= tank_full;
    end
  end

  always_comb begin
    // start and stop
    outlet_open_next        = outlet_open;
    continuous_latched_next = continuous_latched;
    cup_latched_next        = cup_latched;
    base_latched_next       = base_latched;
    if (t_stop) begin
      outlet_open_next = 1'b0;
    end else if (t_start && !outlet_open) begin
      outlet_open_next        = 1'b1;
      continuous_latched_next = t_cont;
      cup_latched_next        = t_cup;
      base_latched_next       = t_base;
    end

    // window bookkeeping, on the sum as it stood before this tick
    window_ticks_next = window_ticks;
    window_armed_next = window_armed;
    extra_active_next = extra_active;
    volume_acc_next   = volume_acc;
    win_inc = (&window_ticks) ? window_ticks : window_ticks + 1'b1;
    if (t_full) begin
      volume_acc_next   = '0;
      window_ticks_next = '0;
      extra_active_next = 1'b0;
      window_armed_next = 1'b1;
    end else if (window_armed) begin
      window_ticks_next = win_inc;
      if (win_inc >= check_window_ticks) begin
        if (volume_acc < dtc_pkg::VOL_TRIGGER) window_armed_next = 1'b0;
        if (win_inc >= max_window_ticks) begin
          window_ticks_next = max_window_ticks;
          window_armed_next = 1'b0;
        end
      end else if (volume_acc >= dtc_pkg::VOL_TRIGGER) begin
        extra_active_next = 1'b1;
        window_ticks_next = check_window_ticks;
      end
    end else begin
      extra_active_next = 1'b0;
    end

    // volume estimate bookkeeping
    ot_mid             = t_full ? '0 : open_ticks;
    open_ticks_next    = ot_mid;
    nominal_total_next = t_full ? '0 : nominal_total;
    nominal_size_next  = t_full ? '0 : nominal_size;
    need_div           = 1'b0;
    if (outlet_open_next) begin
      open_ticks_next    = (&ot_mid) ? ot_mid : ot_mid + 1'b1;
      nominal_total_next = base_latched_next;
      nominal_size_next  = dtc_pkg::pick_size(continuous_latched_next, cup_latched_next,
                                              model_is_r_type);
    end else if (ot_mid != '0) begin
      need_div        = (nominal_total_next != '0);
      open_ticks_next = '0;
    end else begin
      nominal_total_next = '0;
      nominal_size_next  = '0;
    end

    // dispense timer
    if (!extra_active_next) begin
      extra_pick = '0;
    end else if (model_is_r_type) begin
      if (cup_latched_next == dtc_pkg::CUP_HALF) extra_pick = extra_one;
      else if (cup_latched_next == dtc_pkg::CUP_ONE) extra_pick = extra_two;
      else extra_pick = extra_liter;
    end else begin
      if (cup_latched_next == dtc_pkg::CUP_HALF) extra_pick = extra_half;
      else if (cup_latched_next == dtc_pkg::CUP_ONE) extra_pick = extra_one;
      else extra_pick = extra_two;
    end
    target_sum = {1'b0, base_latched_next}
               + (continuous_latched_next ? '0 : (TW+1)'(extra_pick));
    target     = target_sum[TW] ? '1 : target_sum[TW-1:0];
    run_inc    = {1'b0, run_ticks} + 1'b1;
    end_flag_next  = 1'b0;
    run_ticks_next = '0;
    if (outlet_open_next) begin
      if (run_inc >= {1'b0, target}) begin
        outlet_open_next        = 1'b0;
        base_latched_next       = '0;
        continuous_latched_next = 1'b0;
        end_flag_next           = 1'b1;
      end else begin
        run_ticks_next = run_inc[TW-1:0];
      end
    end
  end

  assign product = PW'(open_ticks) * PW'(nominal_size);

  // restoring divider, one quotient bit a cycle
  assign trial    = {div_rem, div_quo[PW-1]};
  assign trial_ge = trial >= {1'b0, divisor};

  assign add_clip = (div_quo > PW'(dtc_pkg::VOL_CAP)) ? dtc_pkg::VOL_CAP : div_quo[VW-1:0];
  assign acc_sum  = {1'b0, volume_acc} + {1'b0, add_clip};

  always_ff @(posedge clk) begin
    if (rst) begin
      outlet_open        <= 1'b0;
      continuous_latched <= 1'b0;
      cup_latched        <= '0;
      base_latched       <= '0;
      run_ticks          <= '0;
      open_ticks         <= '0;
      nominal_total      <= '0;
      nominal_size       <= '0;
      volume_acc         <= '0;
      window_ticks       <= '0;
      window_armed       <= 1'b0;
      extra_active       <= 1'b0;
      end_flag           <= 1'b0;
      div_cnt            <= '0;
    end else if (cmd.exec) begin
      outlet_open        <= outlet_open_next;
      continuous_latched <= continuous_latched_next;
      cup_latched        <= cup_latched_next;
      base_latched       <= base_latched_next;
      run_ticks          <= run_ticks_next;
      open_ticks         <= open_ticks_next;
      nominal_total      <= nominal_total_next;
      nominal_size       <= nominal_size_next;
      volume_acc         <= volume_acc_next;
      window_ticks       <= window_ticks_next;
      window_armed       <= window_armed_next;
      extra_active       <= extra_active_next;
      end_flag           <= end_flag_next;
      div_cnt            <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 1'b1;
    end else if (cmd.acc) begin
      volume_acc <= (acc_sum > (VW+1)'(dtc_pkg::VOL_CAP)) ? dtc_pkg::VOL_CAP
                                                          : acc_sum[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      div_quo <= product;
      div_rem <= '0;
      divisor <= nominal_total;
    end else if (cmd.div_step) begin
      div_rem <= trial_ge ? TW'(trial - {1'b0, divisor}) : trial[TW-1:0];
      div_quo <= {div_quo[PW-2:0], trial_ge};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      dispensing   <= outlet_open;
      dispense_end <= end_flag;
      volume_sum   <= volume_acc;
      compensating <= extra_active;
    end
  end

  assign sts.need_div = need_div;
  assign sts.div_last = (div_cnt == CW'(PW - 1));
  assign sts.out_free = !out_valid || out_ready;

endmodule

// ===== verif/dtc_tick_checker.sv =====
// dtc_tick_checker: watches the tick, result and register channels of the dispense timer,
// keeps its own model of the timer and volume estimate, and compares every result beat.
// Depends on dtc_pkg.
`timescale 1ns / 1ps

module dtc_tick_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           start_req,
  input  logic                           stop,
  input  logic                           continuous,
  input  logic [dtc_pkg::CUP_W-1:0]      cup_level,
  input  logic [dtc_pkg::TICK_W-1:0]     base_time,
  input  logic                           tank_full,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           dispensing,
  input  logic                           dispense_end,
  input  logic [dtc_pkg::VOL_W-1:0]      volume_sum,
  input  logic                           compensating,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [dtc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dtc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             pending,
  output int                             results,
  output int                             end_pulses,
  output int                             comp_ticks
);

  localparam int REPORT_LIMIT = 10;
  localparam int VW = dtc_pkg::VOL_W;
  localparam logic [dtc_pkg::TICK_W-1:0] TICK_SAT = '1;

  typedef struct packed {
    logic                      dispensing;
    logic                      dispense_end;
    logic [dtc_pkg::VOL_W-1:0] volume_sum;
    logic                      compensating;
  } tick_report_t;

  // register copy
  logic                        big_model;
  logic [dtc_pkg::TICK_W-1:0]  check_win, max_win;
  logic [dtc_pkg::EXTRA_W-1:0] x_half, x_one, x_two, x_liter;

  // timer and volume state
  logic                        outlet, cont_l;
  logic [dtc_pkg::CUP_W-1:0]   cup_l;
  logic [dtc_pkg::TICK_W-1:0]  base_l, run_cnt, open_cnt, nom_total, win_cnt;
  logic [dtc_pkg::VOL_W-1:0]   nom_size, vol_acc;
  logic                        armed, extra_on;

  tick_report_t tick_reports[$];

  function automatic logic [dtc_pkg::VOL_W-1:0] cup_volume();
    if (cont_l) return dtc_pkg::VOL_CAP;
    case (cup_l)
      dtc_pkg::CUP_HALF: return big_model ? dtc_pkg::CUP_BIG_HALF : dtc_pkg::CUP_SMALL_HALF;
      dtc_pkg::CUP_ONE:  return big_model ? dtc_pkg::CUP_BIG_ONE : dtc_pkg::CUP_SMALL_ONE;
      default:  return big_model ? dtc_pkg::CUP_BIG_LARGE : dtc_pkg::CUP_SMALL_LARGE;
    endcase
  endfunction

  // the larger model shifts the extras up by one cup size
  function automatic logic [dtc_pkg::EXTRA_W-1:0] extra_ticks();
    if (!extra_on) return '0;
    case (cup_l)
      dtc_pkg::CUP_HALF: return big_model ? x_one : x_half;
      dtc_pkg::CUP_ONE:  return big_model ? x_two : x_one;
      default:  return big_model ? x_liter : x_two;
    endcase
  endfunction

  task automatic timer_tick(input logic st_req, input logic stp, input logic cont,
                            input logic [dtc_pkg::CUP_W-1:0] cup,
                            input logic [dtc_pkg::TICK_W-1:0] base,
                            input logic full, output tick_report_t r);
    int unsigned quot, total, target;
    logic ended;
    ended = 1'b0;

    if (stp) begin
      outlet = 1'b0;
    end else if (st_req && !outlet) begin
      outlet = 1'b1;
      cont_l = cont;
      cup_l  = cup;
      base_l = base;
    end

    if (full) begin
      open_cnt  = '0;
      nom_total = '0;
      nom_size  = '0;
      vol_acc   = '0;
      win_cnt   = '0;
      extra_on  = 1'b0;
      armed     = 1'b1;
    end else if (armed) begin
      if (win_cnt != TICK_SAT) win_cnt++;
      if (win_cnt >= check_win) begin
        if (vol_acc < dtc_pkg::VOL_TRIGGER) armed = 1'b0;
        if (win_cnt >= max_win) begin
          win_cnt = max_win;
          armed   = 1'b0;
        end
      end else if (vol_acc >= dtc_pkg::VOL_TRIGGER) begin
        extra_on = 1'b1;
        win_cnt  = check_win;
      end
    end else begin
      extra_on = 1'b0;
    end

    // volume is folded in on the first closed tick after a dispense
    if (outlet) begin
      if (open_cnt != TICK_SAT) open_cnt++;
      nom_total = base_l;
      nom_size  = cup_volume();
    end else if (open_cnt != '0) begin
      if (nom_total != '0) begin
        quot  = (32'(open_cnt) * 32'(nom_size)) / 32'(nom_total);
        total = 32'(vol_acc) + ((quot > dtc_pkg::VOL_CAP) ? 32'(dtc_pkg::VOL_CAP) : quot);
        vol_acc = (total > dtc_pkg::VOL_CAP) ? dtc_pkg::VOL_CAP : VW'(total);
      end
      open_cnt = '0;
    end else begin
      nom_total = '0;
      nom_size  = '0;
    end

    if (outlet) begin
      target = base_l;
      if (!cont_l) target += extra_ticks();
      if (target > TICK_SAT) target = TICK_SAT;
      run_cnt++;
      if (run_cnt >= target) begin
        outlet  = 1'b0;
        run_cnt = '0;
        base_l  = '0;
        cont_l  = 1'b0;
        ended   = 1'b1;
      end
    end else begin
      run_cnt = '0;
    end

    r = '{dispensing: outlet, dispense_end: ended, volume_sum: vol_acc,
          compensating: extra_on};
  endtask

  always @(posedge clk) begin : watch
    tick_report_t want, got;
    if (rst) begin
      big_model = 1'b0;
      check_win = dtc_pkg::RST_CHECK_WIN;
      max_win   = dtc_pkg::RST_MAX_WIN;
      x_half    = dtc_pkg::RST_EXTRA_HALF;
      x_one     = dtc_pkg::RST_EXTRA_ONE;
      x_two     = dtc_pkg::RST_EXTRA_TWO;
      x_liter   = dtc_pkg::RST_EXTRA_LITER;
      outlet = 1'b0; cont_l = 1'b0; cup_l = '0; base_l = '0;
      run_cnt = '0; open_cnt = '0; nom_total = '0; nom_size = '0;
      vol_acc = '0; win_cnt = '0; armed = 1'b0; extra_on = 1'b0;
      tick_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          dtc_pkg::CFG_MODEL:       big_model = cfg_data[0];
          dtc_pkg::CFG_CHECK_WIN:   check_win = cfg_data;
          dtc_pkg::CFG_MAX_WIN:     max_win   = cfg_data;
          dtc_pkg::CFG_EXTRA_HALF:  x_half    = cfg_data[dtc_pkg::EXTRA_W-1:0];
          dtc_pkg::CFG_EXTRA_ONE:   x_one     = cfg_data[dtc_pkg::EXTRA_W-1:0];
          dtc_pkg::CFG_EXTRA_TWO:   x_two     = cfg_data[dtc_pkg::EXTRA_W-1:0];
          dtc_pkg::CFG_EXTRA_LITER: x_liter   = cfg_data[dtc_pkg::EXTRA_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        timer_tick(start_req, stop, continuous, cup_level, base_time, tank_full, want);
        tick_reports.push_back(want);
      end

      if (out_valid && out_ready) begin
        got = '{dispensing: dispensing, dispense_end: dispense_end,
                volume_sum: volume_sum, compensating: compensating};
        results++;
        if (got.dispense_end === 1'b1) end_pulses++;
        if (got.compensating === 1'b1) comp_ticks++;
        if (tick_reports.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("%t: result beat %0d arrived with no tick outstanding", $time, results);
          mismatches++;
        end else begin
          want = tick_reports.pop_front();
          if (got.dispensing !== want.dispensing || got.dispense_end !== want.dispense_end ||
              got.volume_sum !== want.volume_sum || got.compensating !== want.compensating) begin
            if (mismatches < REPORT_LIMIT)
              $display("%t: beat %0d exp/act disp %b/%b end %b/%b vol %0d/%0d comp %b/%b",
                       $time, results,
                       want.dispensing, got.dispensing, want.dispense_end, got.dispense_end,
                       want.volume_sum, got.volume_sum, want.compensating, got.compensating);
            mismatches++;
          end
        end
      end
    end
    pending = tick_reports.size();
  end

endmodule

// ===== verif/tb_dispense_timer_with_compensation.sv =====
// tb_dispense_timer_with_compensation: drives ticks and register writes into the dispense
// timer with random gaps and back-pressure, and gives the verdict.
// Depends on dtc_pkg, dispense_timer_with_compensation and dtc_tick_checker.
`timescale 1ns / 1ps

module tb_dispense_timer_with_compensation;

  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 7;
  localparam int PHASES         = 8;
  localparam int PHASE_TICKS    = 250;
  localparam int MARATHON_TICKS = 120;
  localparam int PRESSURE_AT    = 700;
  localparam int HOLD_CYCLES    = 300;
  localparam int MAX_GAP        = 13;
  localparam int TAIL_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 5000;

  localparam int TW  = dtc_pkg::TICK_W;
  localparam int CPW = dtc_pkg::CUP_W;
  localparam int XW  = dtc_pkg::EXTRA_W;

  localparam logic [CPW-1:0] CUP_LARGE = 2'd2;
  localparam logic [CPW-1:0] CUP_SPARE = 2'd3;

  typedef struct {
    logic               big_model;
    logic [TW-1:0]      check_win;
    logic [TW-1:0]      max_win;
    logic [XW-1:0]      x_half, x_one, x_two, x_liter;
  } settings_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           start_req = 1'b0;
  logic                           stop = 1'b0;
  logic                           continuous = 1'b0;
  logic [CPW-1:0]                 cup_level = '0;
  logic [TW-1:0]                  base_time = '0;
  logic                           tank_full = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic                           dispensing, dispense_end, compensating;
  logic [dtc_pkg::VOL_W-1:0]      volume_sum;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [dtc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [dtc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int mismatches, pending, results, end_pulses, comp_ticks;
  int ticks_sent = 0;
  int idle_cycles = 0;
  bit send_steady = 1'b0;
  bit recv_steady = 1'b0;
  bit marathon = 1'b0;

  dispense_timer_with_compensation dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .start_req(start_req), .stop(stop), .continuous(continuous),
    .cup_level(cup_level), .base_time(base_time), .tank_full(tank_full),
    .out_valid(out_valid), .out_ready(out_ready),
    .dispensing(dispensing), .dispense_end(dispense_end),
    .volume_sum(volume_sum), .compensating(compensating),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  dtc_tick_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .start_req(start_req), .stop(stop), .continuous(continuous),
    .cup_level(cup_level), .base_time(base_time), .tank_full(tank_full),
    .out_valid(out_valid), .out_ready(out_ready),
    .dispensing(dispensing), .dispense_end(dispense_end),
    .volume_sum(volume_sum), .compensating(compensating),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending), .results(results),
    .end_pulses(end_pulses), .comp_ticks(comp_ticks)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic int pick_gap(input bit steady);
    return steady ? 0 : int'($urandom_range(0, MAX_GAP));
  endfunction

  // valid is left high after the beat; a gap or the caller lowers it
  task automatic send_tick(input logic st_req, input logic stp, input logic cont,
                           input logic [CPW-1:0] cup, input logic [TW-1:0] base,
                           input logic full);
    int gap;
    gap = pick_gap(send_steady || marathon);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    start_req  <= st_req;
    stop       <= stp;
    continuous <= cont;
    cup_level  <= cup;
    base_time  <= base;
    tank_full  <= full;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ticks_sent++;
  endtask

  task automatic random_ticks(input int n);
    int unsigned pick;
    logic [TW-1:0] base;
    repeat (n) begin
      if (ticks_sent % 64 == 0) send_steady = ($urandom_range(0, 3) == 0);
      // mostly short dispenses so the volume and window logic gets exercised
      pick = $urandom_range(0, 99);
      if (pick < 70)      base = TW'($urandom_range(0, 12));
      else if (pick < 95) base = TW'($urandom_range(13, 300));
      else if (pick < 98) base = TW'($urandom);
      else                base = TW'(16'hFFFF - $urandom_range(0, 300));
      send_tick($urandom_range(0, 3) == 0, $urandom_range(0, 39) == 0,
                $urandom_range(0, 5) == 0, CPW'($urandom_range(0, 3)), base,
                $urandom_range(0, 149) == 0);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [dtc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dtc_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // upper data bits are junk for the narrow registers
  task automatic load_settings(input settings_t s);
    write_reg(dtc_pkg::CFG_MODEL,       {15'($urandom), s.big_model});
    write_reg(dtc_pkg::CFG_CHECK_WIN,   s.check_win);
    write_reg(dtc_pkg::CFG_MAX_WIN,     s.max_win);
    write_reg(dtc_pkg::CFG_EXTRA_HALF,  {8'($urandom), s.x_half});
    write_reg(dtc_pkg::CFG_EXTRA_ONE,   {8'($urandom), s.x_one});
    write_reg(dtc_pkg::CFG_EXTRA_TWO,   {8'($urandom), s.x_two});
    write_reg(dtc_pkg::CFG_EXTRA_LITER, {8'($urandom), s.x_liter});
    cfg_valid <= 1'b0;
  endtask

  // result side: random stalls, plus two long hold-offs to back the block up
  initial begin
    int gap;
    int taken;
    taken = 0;
    @(posedge clk);
    forever begin
      if (taken % 64 == 0) recv_steady = ($urandom_range(0, 3) == 0);
      if (taken == PRESSURE_AT || taken == 2 * PRESSURE_AT) gap = HOLD_CYCLES;
      else gap = pick_gap(recv_steady || marathon);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%t: no beat on any channel for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb_dispense_timer_with_compensation: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    settings_t s;
    int phase;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed ticks at the reset register values
    send_tick(1'b0, 1'b0, 1'b0, dtc_pkg::CUP_HALF, 16'd0, 1'b1);     // full tank arms window
    send_tick(1'b1, 1'b1, 1'b0, CUP_LARGE, 16'd5, 1'b0);             // stop wins over start
    send_tick(1'b1, 1'b0, 1'b0, CUP_SPARE, 16'd3, 1'b0);             // unused cup code
    send_tick(1'b1, 1'b0, 1'b1, dtc_pkg::CUP_HALF, 16'hFFFF, 1'b0);  // start while open
    repeat (3) send_tick(1'b0, 1'b0, 1'b0, dtc_pkg::CUP_HALF, 16'd0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0, dtc_pkg::CUP_ONE, 16'd0, 1'b0);      // zero base, no volume
    send_tick(1'b0, 1'b0, 1'b0, dtc_pkg::CUP_HALF, 16'd0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b1, dtc_pkg::CUP_ONE, 16'd2, 1'b0);      // continuous, hits the cap
    repeat (3) send_tick(1'b0, 1'b0, 1'b0, dtc_pkg::CUP_HALF, 16'd0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0, CUP_LARGE, 16'hFFFF, 1'b0);          // base plus extra saturates
    send_tick(1'b0, 1'b0, 1'b0, dtc_pkg::CUP_HALF, 16'd0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0, dtc_pkg::CUP_HALF, 16'd0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0, dtc_pkg::CUP_HALF, 16'd0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0, dtc_pkg::CUP_HALF, 16'd1, 1'b0);
    random_ticks(PHASE_TICKS - ticks_sent);

    for (phase = 1; phase < PHASES; phase++) begin
      settle();
      if (phase == 1) begin
        s = '{1'b0, '0, '0, '0, '0, '0, '0};
      end else if (phase == PHASES - 1) begin
        s = '{1'b1, '1, '1, '1, '1, '1, '1};
      end else begin
        s.big_model = $urandom_range(0, 1);
        s.check_win = TW'($urandom_range(10, 400));
        s.max_win   = ($urandom_range(0, 3) == 0) ? TW'($urandom_range(0, s.check_win))
                                                  : s.check_win + TW'($urandom_range(0, 1500));
        s.x_half    = XW'($urandom);
        s.x_one     = XW'($urandom);
        s.x_two     = XW'($urandom);
        s.x_liter   = XW'($urandom);
      end
      load_settings(s);
      send_tick(1'b0, 1'b0, 1'b0, dtc_pkg::CUP_HALF, 16'd0, 1'b1);
      random_ticks(PHASE_TICKS);
    end

    // a long dispense fed back to back with no gaps on either side
    marathon = 1'b1;
    repeat (MARATHON_TICKS) send_tick(1'b1, 1'b0, 1'b0, CUP_LARGE, 16'hFFFF, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0, dtc_pkg::CUP_HALF, 16'd0, 1'b0);
    repeat (3) send_tick(1'b0, 1'b0, 1'b0, dtc_pkg::CUP_HALF, 16'd0, 1'b0);
    marathon = 1'b0;

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d ticks over %0d register settings incl. minimum, maximum and a %0d-tick run",
             ticks_sent, PHASES, MARATHON_TICKS);
    $display("%0d results checked: %0d end pulses, %0d ticks with compensation, %0d mismatches",
             results, end_pulses, comp_ticks, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_dispense_timer_with_compensation: clean");
    end else begin
      $display("tb_dispense_timer_with_compensation: errors");
    end
    $finish;
  end

endmodule
